>>> rtl/cubic_bezier_line_intersect_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the cubic Bezier line intersection block
// Clocked on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef CUBIC_BEZIER_LINE_INTERSECT_MACROS_SVH
`define CUBIC_BEZIER_LINE_INTERSECT_MACROS_SVH

// antecedent holds: consequent in the same cycle
`define CBLI_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// antecedent holds: consequent in the next cycle
`define CBLI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/cbli_pkg.sv
// ----------------------------------------------------------------------------
// cbli_pkg
// Types, constants and microcode encoding for the Bezier line intersection.
// ----------------------------------------------------------------------------
package cbli_pkg;

  localparam int unsigned MAX_ROUNDS_DEF = 10;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned WGT_W   = 18;
  localparam int unsigned ACC_W   = 38;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned NUM_REGS  = 8;
  localparam int unsigned PC_W    = 4;

  localparam logic [FRAC_W-1:0] U_START    = 16'h8000;
  localparam logic [FRAC_W-1:0] STEP_START = 16'h4000;
  localparam logic signed [COORD_W:0] TOL_LSB = 33'sd65;

  localparam logic [CFG_IDX_W-1:0] REG_CTRL0_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CTRL0_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CTRL1_X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CTRL1_Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CTRL2_X = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CTRL2_Y = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CTRL3_X = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_CTRL3_Y = 3'd7;

  typedef enum logic [1:0] {
    ACT_MUL   = 2'd0,
    ACT_TESTX = 2'd1,
    ACT_DONE  = 2'd2
  } act_t;

  typedef enum logic [2:0] {
    A_U  = 3'd0,
    A_V  = 3'd1,
    A_U2 = 3'd2,
    A_V2 = 3'd3,
    A_W  = 3'd4
  } asel_t;

  typedef enum logic [1:0] {
    B_U   = 2'd0,
    B_V   = 2'd1,
    B_CRD = 2'd2
  } bsel_t;

  typedef enum logic [2:0] {
    D_NONE = 3'd0,
    D_U2   = 3'd1,
    D_V2   = 3'd2,
    D_W    = 3'd3,
    D_ACC  = 3'd4
  } dst_t;

  typedef struct packed {
    act_t                 act;
    asel_t                a_sel;
    logic [1:0]           widx;
    bsel_t                b_sel;
    logic [CFG_IDX_W-1:0] crd;
    dst_t                 dst;
    logic                 triple;
    logic                 acc_clr;
  } uc_t;

  typedef struct packed {
    logic load;
    logic mul_en;
    logic upd;
    logic fin_hit;
    logic fin_miss;
  } dp_ctl_t;

  function automatic uc_t uc_mul(input asel_t a, input logic [1:0] w, input bsel_t b,
                                 input logic [CFG_IDX_W-1:0] c, input dst_t d,
                                 input logic tri3, input logic clr);
    uc_t r;
    r.act     = ACT_MUL;
    r.a_sel   = a;
    r.widx    = w;
    r.b_sel   = b;
    r.crd     = c;
    r.dst     = d;
    r.triple  = tri3;
    r.acc_clr = clr;
    return r;
  endfunction

  function automatic uc_t uc_ctl(input act_t a);
    uc_t r;
    r         = uc_mul(A_U, 2'd0, B_U, REG_CTRL0_X, D_NONE, 1'b0, 1'b0);
    r.act     = a;
    return r;
  endfunction

endpackage

>>> rtl/cbli_ucode_rom.sv
// ----------------------------------------------------------------------------
// cbli_ucode_rom
// Control store: one evaluation, tolerance test and y accumulation.
// ----------------------------------------------------------------------------
module cbli_ucode_rom (
  input  logic [cbli_pkg::PC_W-1:0] pc,
  output cbli_pkg::uc_t             uc
);
  import cbli_pkg::*;

  always_comb begin
    unique case (pc)
      4'd0:  uc = uc_mul(A_U,  2'd0, B_U,   REG_CTRL0_X, D_U2,  1'b0, 1'b0);
      4'd1:  uc = uc_mul(A_V,  2'd0, B_V,   REG_CTRL0_X, D_V2,  1'b0, 1'b0);
      4'd2:  uc = uc_mul(A_U2, 2'd3, B_U,   REG_CTRL0_X, D_W,   1'b0, 1'b0);
      4'd3:  uc = uc_mul(A_V2, 2'd0, B_V,   REG_CTRL0_X, D_W,   1'b0, 1'b0);
      4'd4:  uc = uc_mul(A_V2, 2'd1, B_U,   REG_CTRL0_X, D_W,   1'b1, 1'b0);
      4'd5:  uc = uc_mul(A_U2, 2'd2, B_V,   REG_CTRL0_X, D_W,   1'b1, 1'b0);
      4'd6:  uc = uc_mul(A_W,  2'd0, B_CRD, REG_CTRL0_X, D_ACC, 1'b0, 1'b1);
      4'd7:  uc = uc_mul(A_W,  2'd1, B_CRD, REG_CTRL1_X, D_ACC, 1'b0, 1'b0);
      4'd8:  uc = uc_mul(A_W,  2'd2, B_CRD, REG_CTRL2_X, D_ACC, 1'b0, 1'b0);
      4'd9:  uc = uc_mul(A_W,  2'd3, B_CRD, REG_CTRL3_X, D_ACC, 1'b0, 1'b0);
      4'd10: uc = uc_ctl(ACT_TESTX);
      4'd11: uc = uc_mul(A_W,  2'd0, B_CRD, REG_CTRL0_Y, D_ACC, 1'b0, 1'b1);
      4'd12: uc = uc_mul(A_W,  2'd1, B_CRD, REG_CTRL1_Y, D_ACC, 1'b0, 1'b0);
      4'd13: uc = uc_mul(A_W,  2'd2, B_CRD, REG_CTRL2_Y, D_ACC, 1'b0, 1'b0);
      4'd14: uc = uc_mul(A_W,  2'd3, B_CRD, REG_CTRL3_Y, D_ACC, 1'b0, 1'b0);
      4'd15: uc = uc_ctl(ACT_DONE);
    endcase
  end

endmodule

>>> rtl/cbli_seq.sv
// ----------------------------------------------------------------------------
// cbli_seq
// Step counter, round counter and branch logic of the microcode engine.
// ----------------------------------------------------------------------------
module cbli_seq #(
  parameter int unsigned MAX_ROUNDS = cbli_pkg::MAX_ROUNDS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  cbli_pkg::uc_t             uc,
  input  logic                      hit,
  output logic [cbli_pkg::PC_W-1:0] pc,
  output cbli_pkg::dp_ctl_t         ctl,
  output logic                      busy,
  output logic                      done,
  output logic                      found
);
  import cbli_pkg::*;

  localparam int unsigned RND_W = $clog2(MAX_ROUNDS + 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } state_t;

  state_t           state;
  logic [RND_W-1:0] round;
  logic             last;

  assign busy = (state == S_RUN);
  assign last = (round == RND_W'(MAX_ROUNDS));

  always_comb begin
    ctl.load     = (state == S_IDLE) && start;
    ctl.mul_en   = busy && (uc.act == ACT_MUL);
    ctl.upd      = busy && (uc.act == ACT_TESTX) && !hit;
    ctl.fin_hit  = busy && (uc.act == ACT_DONE);
    ctl.fin_miss = busy && (uc.act == ACT_TESTX) && !hit && last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pc    <= '0;
      round <= '0;
      done  <= 1'b0;
      found <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_RUN;
            pc    <= '0;
            round <= '0;
          end
        end
        S_RUN: begin
          unique case (uc.act)
            ACT_MUL: pc <= pc + 1'b1;
            ACT_TESTX: begin
              if (hit) begin
                pc <= pc + 1'b1;
              end else if (last) begin
                state <= S_IDLE;
                done  <= 1'b1;
                found <= 1'b0;
              end else begin
                pc    <= '0;
                round <= round + 1'b1;
              end
            end
            ACT_DONE: begin
              state <= S_IDLE;
              done  <= 1'b1;
              found <= 1'b1;
            end
            default: state <= S_IDLE;
          endcase
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/cbli_datapath.sv
// ----------------------------------------------------------------------------
// cbli_datapath
// Control point registers, bisection state and the shared multiplier.
// ----------------------------------------------------------------------------
module cbli_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_en,
  input  logic [cbli_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [cbli_pkg::COORD_W-1:0]   wr_data,
  input  logic signed [31:0]             query_x,
  input  cbli_pkg::uc_t                  uc,
  input  cbli_pkg::dp_ctl_t              ctl,
  output logic                           hit,
  output logic signed [31:0]             cross_y
);
  import cbli_pkg::*;

  localparam logic signed [ACC_W-1:0] SAT_HI = 38'sd2147483647;
  localparam logic signed [ACC_W-1:0] SAT_LO = -38'sd2147483648;

  function automatic logic signed [COORD_W-1:0] sat32(input logic signed [ACC_W-1:0] a);
    if (a > SAT_HI) begin
      return SAT_HI[COORD_W-1:0];
    end else if (a < SAT_LO) begin
      return SAT_LO[COORD_W-1:0];
    end
    return a[COORD_W-1:0];
  endfunction

  logic [COORD_W-1:0]        cfg [NUM_REGS];
  logic signed [COORD_W-1:0] qx;
  logic [FRAC_W-1:0]         u;
  logic [FRAC_W-1:0]         v;
  logic [FRAC_W-1:0]         step;
  logic [FRAC_W-1:0]         u2;
  logic [FRAC_W-1:0]         v2;
  logic [WGT_W-1:0]          w [4];
  logic signed [ACC_W-1:0]   acc;

  logic [WGT_W-1:0]          a_val;
  logic signed [COORD_W:0]   b_val;
  logic signed [WGT_W+COORD_W+1:0] prod;
  logic [FRAC_W-1:0]         pow;
  logic [WGT_W-1:0]          pow3;
  logic signed [35:0]        term;
  logic signed [COORD_W-1:0] cx;
  logic signed [COORD_W:0]   d;
  logic                      gt;

  assign v = 16'd0 - u;

  always_comb begin
    unique case (uc.a_sel)
      A_U:     a_val = {2'b00, u};
      A_V:     a_val = {2'b00, v};
      A_U2:    a_val = {2'b00, u2};
      A_V2:    a_val = {2'b00, v2};
      A_W:     a_val = w[uc.widx];
      default: a_val = '0;
    endcase
    unique case (uc.b_sel)
      B_U:     b_val = {17'd0, u};
      B_V:     b_val = {17'd0, v};
      B_CRD:   b_val = {cfg[uc.crd][COORD_W-1], cfg[uc.crd]};
      default: b_val = '0;
    endcase
  end

  assign prod = $signed({1'b0, a_val}) * b_val;
  assign pow  = prod[31:16];
  assign pow3 = {1'b0, pow, 1'b0} + {2'b00, pow};
  assign term = prod[51:16];

  assign cx  = sat32(acc);
  assign d   = {qx[COORD_W-1], qx} - {cx[COORD_W-1], cx};
  assign hit = (d <= TOL_LSB) && (d >= -TOL_LSB);
  assign gt  = d[COORD_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        cfg[i] <= '0;
      end
    end else if (wr_en) begin
      cfg[wr_index] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      qx   <= query_x;
      u    <= U_START;
      step <= STEP_START;
    end else if (ctl.upd) begin
      u    <= gt ? (u - step) : (u + step);
      step <= step >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      unique case (uc.dst)
        D_U2:  u2 <= pow;
        D_V2:  v2 <= pow;
        D_W:   w[uc.widx] <= uc.triple ? pow3 : {2'b00, pow};
        D_ACC: begin
          if (uc.acc_clr) begin
            acc <= {{2{term[35]}}, term};
          end else begin
            acc <= acc + {{2{term[35]}}, term};
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.fin_hit) begin
      cross_y <= sat32(acc);
    end else if (ctl.fin_miss) begin
      cross_y <= '0;
    end
  end

endmodule

>>> rtl/cubic_bezier_line_intersect.sv
// ----------------------------------------------------------------------------
// cubic_bezier_line_intersect
// Bisection search for the crossing of a cubic Bezier curve with X = query_x.
// ----------------------------------------------------------------------------
// Usage:
//   Write the four control points (x, y pairs, signed Q16.16) through wr_en,
//   wr_index and wr_data while the block is idle; index 0 is ctrl0_x up to
//   index 7 for ctrl3_y. Writes take effect at the clock edge.
//   Pulse start with query_x while busy is low; the transaction is taken at
//   that edge and busy rises.
//   Each bisection round runs six power products, four x terms and the
//   tolerance test, all through one 18x33 multiplier that the microcode
//   steps through. A hit then runs the four y terms and the done step;
//   a miss ends once none of the MAX_ROUNDS + 1 evaluations has hit.
//   done is high for exactly one cycle with cross_y and found; busy is low
//   in that cycle, so the next start may be taken there.
//   The receiver cannot stall: the result is valid for that single cycle.
//   Reset clears the control points to zero and drops any transaction.
// ----------------------------------------------------------------------------
module cubic_bezier_line_intersect #(
  parameter int unsigned MAX_ROUNDS = cbli_pkg::MAX_ROUNDS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_en,
  input  logic [cbli_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [cbli_pkg::COORD_W-1:0]   wr_data,
  input  logic                           start,
  input  logic signed [31:0]             query_x,
  output logic                           busy,
  output logic                           done,
  output logic signed [31:0]             cross_y,
  output logic                           found
);
  import cbli_pkg::*;

  logic [PC_W-1:0] pc;
  uc_t             uc;
  dp_ctl_t         ctl;
  logic            hit;

  cbli_ucode_rom u_rom (
    .pc (pc),
    .uc (uc)
  );

  cbli_seq #(
    .MAX_ROUNDS (MAX_ROUNDS)
  ) u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .uc    (uc),
    .hit   (hit),
    .pc    (pc),
    .ctl   (ctl),
    .busy  (busy),
    .done  (done),
    .found (found)
  );

  cbli_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .query_x  (query_x),
    .uc       (uc),
    .ctl      (ctl),
    .hit      (hit),
    .cross_y  (cross_y)
  );

endmodule

>>> rtl/cbli_checker.sv
// ----------------------------------------------------------------------------
// cbli_checker
// Port-level checks of the intersection block, bound to the top level.
// ----------------------------------------------------------------------------
`include "cubic_bezier_line_intersect_macros.svh"

module cbli_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [31:0] cross_y,
  input logic        found
);

  `CBLI_ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted transaction did not raise busy")
  `CBLI_ASSERT_SAME(a_done_ends, done, !busy && $past(busy), "done without a transaction ending")
  `CBLI_ASSERT_NEXT(a_done_pulse, done, !done, "done held longer than one cycle")
  `CBLI_ASSERT_SAME(a_miss_zero, done && !found, cross_y == 32'd0, "miss with non-zero cross_y")

endmodule

bind cubic_bezier_line_intersect cbli_checker u_cbli_checker (.*);

>>> dv/tb_cubic_bezier_line_intersect.sv
// ----------------------------------------------------------------------------
// tb_cubic_bezier_line_intersect
// Self-checking bench for the Bezier / vertical line crossing search. Control
// points are set while the block is idle: zero from reset, a straight ramp,
// extreme coordinates, then random curves. Each query transaction is checked
// against a bit-true bisection predictor. Phases vary how often the sender idles.
// ----------------------------------------------------------------------------
module tb_cubic_bezier_line_intersect;
  timeunit 1ns;
  timeprecision 1ps;
  import cbli_pkg::*;

  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int DRAIN_CYCLES = 11 * (MAX_ROUNDS_DEF + 1) + 10;
  localparam int RANDOM_SETS  = 14;
  localparam int SET_ITEMS    = 100;
  localparam int IDLE_PCT [3] = '{0, 74, 27};

  typedef struct packed {
    logic signed [31:0] cross_y;
    logic               found;
  } crossing_t;

  logic                 clk      = 1'b0;
  logic                 rst      = 1'b1;
  logic                 wr_en    = 1'b0;
  logic [CFG_IDX_W-1:0] wr_index = '0;
  logic [COORD_W-1:0]   wr_data  = '0;
  logic                 start    = 1'b0;
  logic signed [31:0]   query_x  = '0;
  logic                 busy;
  logic                 done;
  logic signed [31:0]   cross_y;
  logic                 found;

  logic signed [31:0] ctrl_pt [NUM_REGS] = '{default: '0};
  logic signed [31:0] next_pt [NUM_REGS] = '{default: '0};
  logic signed [31:0] query_q [$];
  crossing_t          crossing_q [$];
  int                 idle_pct     = 0;
  int                 queued_cnt   = 0;
  int                 accepted_cnt = 0;
  int                 errors       = 0;
  int                 cycle_cnt    = 0;

  cubic_bezier_line_intersect #(
    .MAX_ROUNDS(MAX_ROUNDS_DEF)
  ) dut (
    .clk(clk),
    .rst(rst),
    .wr_en(wr_en),
    .wr_index(wr_index),
    .wr_data(wr_data),
    .start(start),
    .query_x(query_x),
    .busy(busy),
    .done(done),
    .cross_y(cross_y),
    .found(found)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint weighted(input longint w, input logic signed [31:0] c);
    return (w * longint'(c)) >>> 16;
  endfunction

  function automatic void curve_at(input longint u, output longint cx, output longint cy);
    longint v, u2, v2, u3, v3, uv2, u2v;
    longint w0, w1, w2, w3;
    v   = 65536 - u;
    u2  = (u * u) >>> 16;
    v2  = (v * v) >>> 16;
    u3  = (u2 * u) >>> 16;
    v3  = (v2 * v) >>> 16;
    uv2 = (u * v2) >>> 16;
    u2v = (u2 * v) >>> 16;
    w0  = v3;
    w1  = 3 * uv2;
    w2  = 3 * u2v;
    w3  = u3;
    cx = clamp32(weighted(w0, ctrl_pt[REG_CTRL0_X]) + weighted(w1, ctrl_pt[REG_CTRL1_X]) +
                 weighted(w2, ctrl_pt[REG_CTRL2_X]) + weighted(w3, ctrl_pt[REG_CTRL3_X]));
    cy = clamp32(weighted(w0, ctrl_pt[REG_CTRL0_Y]) + weighted(w1, ctrl_pt[REG_CTRL1_Y]) +
                 weighted(w2, ctrl_pt[REG_CTRL2_Y]) + weighted(w3, ctrl_pt[REG_CTRL3_Y]));
  endfunction

  function automatic crossing_t find_crossing(input logic signed [31:0] qx);
    longint    u, step, cx, cy, d;
    crossing_t r;
    int        rnd;
    u    = longint'(U_START);
    step = longint'(STEP_START);
    r    = '0;
    for (rnd = 0; rnd <= int'(MAX_ROUNDS_DEF); rnd++) begin
      curve_at(u, cx, cy);
      d = longint'(qx) - cx;
      if (d < 0) d = -d;
      if (d <= TOL_LSB) begin
        r.cross_y = cy[31:0];
        r.found   = 1'b1;
        return r;
      end
      if (cx > longint'(qx)) u -= step;
      else u += step;
      step >>= 1;
    end
    return r;
  endfunction

  // driver: hold start until the transaction is taken
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        crossing_q.push_back(find_crossing(query_x));
        accepted_cnt++;
      end
      if (!start || !busy) begin
        if (query_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          start   <= 1'b1;
          query_x <= query_q.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    crossing_t want;
    if (!rst && done) begin
      if (crossing_q.size() == 0) begin
        $error("unexpected result: cross_y %0d found %0b", cross_y, found);
        errors++;
      end else begin
        want = crossing_q.pop_front();
        if (cross_y !== want.cross_y) begin
          $error("cross_y: expected %0d, got %0d", want.cross_y, cross_y);
          errors++;
        end
        if (found !== want.found) begin
          $error("found: expected %0b, got %0b", want.found, found);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic queue_query(input logic signed [31:0] q);
    query_q.push_back(q);
    queued_cnt++;
  endtask

  task automatic queue_on_curve(input int count);
    longint cx, cy;
    int     n;
    for (n = 0; n < count; n++) begin
      if ($urandom_range(99) < 80) begin
        curve_at(longint'($urandom_range(1, 2047)) * 32, cx, cy);
        queue_query(32'(clamp32(cx + longint'($urandom_range(160)) - 80)));
      end else begin
        queue_query($urandom());
      end
    end
  endtask

  task automatic drain();
    do @(posedge clk);
    while (accepted_cnt != queued_cnt || crossing_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input int idx, input logic signed [31:0] val);
    wr_en    <= 1'b1;
    wr_index <= CFG_IDX_W'(idx);
    wr_data  <= val;
    ctrl_pt[idx] = val;
    @(posedge clk);
  endtask

  task automatic program_curve();
    int i;
    for (i = 0; i < NUM_REGS; i++) write_reg(i, next_pt[i]);
    wr_en <= 1'b0;
  endtask

  task automatic pick_curve(input int k);
    longint base, span, x;
    int     i;
    if (k % 5 == 4) begin
      for (i = 0; i < NUM_REGS; i++) next_pt[i] = $urandom();
    end else begin
      base = longint'($signed($urandom())) >>> 1;
      span = (k % 2) ? $urandom_range(1, 300000) : $urandom_range(1, 3000000);
      if (k % 5 == 3) span = -span;
      for (i = 0; i < 4; i++) begin
        x = base + i * span / 3 + longint'($urandom_range(2000)) - 1000;
        next_pt[REG_CTRL0_X + 2 * i] = 32'(x);
        next_pt[REG_CTRL0_Y + 2 * i] = $urandom();
      end
    end
  endtask

  initial begin
    int k;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // zero curve: only the tolerance band around x = 0 hits
    queue_query(32'sd0);
    queue_query(32'sd65);
    queue_query(-32'sd65);
    queue_query(32'sd66);
    queue_query(-32'sd66);
    queue_query(32'sh7FFFFFFF);
    queue_query(32'sh80000000);
    drain();

    // straight ramp from 0.0 to 3.0
    next_pt[REG_CTRL0_X] = 32'sh0000_0000;
    next_pt[REG_CTRL1_X] = 32'sh0001_0000;
    next_pt[REG_CTRL2_X] = 32'sh0002_0000;
    next_pt[REG_CTRL3_X] = 32'sh0003_0000;
    next_pt[REG_CTRL0_Y] = 32'shFFFB_0000;
    next_pt[REG_CTRL1_Y] = 32'sh0007_0000;
    next_pt[REG_CTRL2_Y] = 32'shFFFD_0000;
    next_pt[REG_CTRL3_Y] = 32'sh000B_0000;
    program_curve();
    queue_query(32'sd98304);
    queue_query(32'sd98369);
    queue_query(32'sd98370);
    queue_query(32'sd0);
    queue_query(32'sd196608);
    queue_query(32'sd300000);
    queue_query(-32'sd300000);
    drain();

    // extreme coordinates
    next_pt[REG_CTRL0_X] = 32'sh80000000;
    next_pt[REG_CTRL1_X] = 32'sh80000000;
    next_pt[REG_CTRL2_X] = 32'sh7FFFFFFF;
    next_pt[REG_CTRL3_X] = 32'sh7FFFFFFF;
    next_pt[REG_CTRL0_Y] = 32'sh7FFFFFFF;
    next_pt[REG_CTRL1_Y] = 32'sh7FFFFFFF;
    next_pt[REG_CTRL2_Y] = 32'sh80000000;
    next_pt[REG_CTRL3_Y] = 32'sh80000000;
    program_curve();
    queue_query(32'sd0);
    queue_query(-32'sd1);
    queue_query(32'sh7FFFFFFF);
    queue_query(32'sh80000000);
    queue_query(32'sd12345678);
    drain();

    for (k = 0; k < RANDOM_SETS; k++) begin
      idle_pct = IDLE_PCT[k % 3];
      pick_curve(k);
      program_curve();
      queue_on_curve(SET_ITEMS);
      drain();
    end

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/cbli_pkg.sv
rtl/cbli_ucode_rom.sv
rtl/cbli_seq.sv
rtl/cbli_datapath.sv
rtl/cubic_bezier_line_intersect.sv
rtl/cbli_checker.sv
dv/tb_cubic_bezier_line_intersect.sv
